// ===== hdl/sgvf_pkg.sv =====
package sgvf_pkg;

	localparam int CoordW = 24;
	localparam int DiffW  = CoordW + 1;
	localparam int HalfW  = 23;
	localparam int GainW  = 16;
	localparam int DirW   = 16;
	localparam int ErrW   = 24;

	localparam int QueueDepthDef = 4;

	localparam logic signed [ErrW-1:0] ErrMax     = 24'sh7FFFFF;
	localparam logic [HalfW-1:0]       HalfSideRst = 23'd25600;
	localparam logic [GainW-1:0]       GainRst     = 16'd256;
	localparam logic signed [1:0]      SignPos     = 2'sd1;
	localparam logic signed [1:0]      SignNeg     = -2'sd1;
	localparam logic signed [1:0]      SignZero    = 2'sd0;
	localparam logic signed [1:0]      SignUnused  = -2'sd2;

	typedef enum logic [2:0] {
		REG_CENTRE_X  = 3'd0,
		REG_CENTRE_Y  = 3'd1,
		REG_HALF_SIDE = 3'd2,
		REG_DIRECTION = 3'd3,
		REG_GAIN      = 3'd4
	} sgvf_reg_t;

	typedef struct packed {
		logic signed [CoordW-1:0] centre_x;
		logic signed [CoordW-1:0] centre_y;
		logic [HalfW-1:0]         half_side;
		logic signed [1:0]        direction;
		logic [GainW-1:0]         gain;
	} sgvf_cfg_t;

	// One classified item: saturated error and the normal's signs.
	typedef struct packed {
		logic signed [ErrW-1:0] e;
		logic signed [1:0]      nx;
		logic signed [1:0]      ny;
	} sgvf_item_t;

endpackage

// ===== hdl/sgvf_front.sv =====
module sgvf_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [sgvf_pkg::CoordW-1:0] point_x,
	input  logic signed [sgvf_pkg::CoordW-1:0] point_y,
	input  sgvf_pkg::sgvf_cfg_t               cfg,
	output logic                              item_valid,
	input  logic                              item_ready,
	output sgvf_pkg::sgvf_item_t              item
);
	import sgvf_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3;
	logic signed [DiffW-1:0] dx_s1, dy_s1;
	logic [DiffW-1:0] adx_s2, ady_s2;
	logic g1_s2, g2_s2;
	sgvf_item_t item_s3;

	logic [DiffW-1:0] amax;
	logic signed [DiffW:0] e_full;
	sgvf_item_t item_d;

	assign adv        = !v_s3 || item_ready;
	assign in_ready   = adv;
	assign item_valid = v_s3;
	assign item       = item_s3;

	always_comb begin
		amax   = (adx_s2 > ady_s2) ? adx_s2 : ady_s2;
		e_full = $signed({1'b0, amax}) - $signed({3'b000, cfg.half_side});
		item_d.e = (e_full > $signed({{(DiffW+1-ErrW){1'b0}}, ErrMax})) ? ErrMax
			: e_full[ErrW-1:0];
		if (adx_s2 > ady_s2) begin
			item_d.nx = g1_s2 ? SignPos : SignNeg;
			item_d.ny = SignZero;
		end else if (ady_s2 > adx_s2) begin
			item_d.nx = SignZero;
			item_d.ny = g2_s2 ? SignPos : SignNeg;
		end else begin
			item_d.nx = g1_s2 ? SignPos : SignNeg;
			item_d.ny = g2_s2 ? SignPos : SignNeg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1   <= $signed({point_x[CoordW-1], point_x})
				- $signed({cfg.centre_x[CoordW-1], cfg.centre_x});
			dy_s1   <= $signed({point_y[CoordW-1], point_y})
				- $signed({cfg.centre_y[CoordW-1], cfg.centre_y});
			adx_s2  <= dx_s1[DiffW-1] ? DiffW'(-dx_s1) : DiffW'(dx_s1);
			ady_s2  <= dy_s1[DiffW-1] ? DiffW'(-dy_s1) : DiffW'(dy_s1);
			g1_s2   <= !dx_s1[DiffW-1];
			g2_s2   <= !dy_s1[DiffW-1];
			item_s3 <= item_d;
		end
	end

endmodule

// ===== hdl/sgvf_queue.sv =====
module sgvf_queue #(
	parameter int DEPTH = sgvf_pkg::QueueDepthDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sgvf_pkg::sgvf_item_t wdata,
	output logic                 full,
	input  logic                 pop,
	output sgvf_pkg::sgvf_item_t rdata,
	output logic                 empty
);
	import sgvf_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	sgvf_item_t mem_q [DEPTH];
	logic [PtrW-1:0] wptr_q, rptr_q;
	logic [CntW-1:0] count_q;
	logic do_push, do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= wdata;
	end

endmodule

// ===== hdl/sgvf_back.sv =====
module sgvf_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_pop,
	input  sgvf_pkg::sgvf_item_t                item,
	input  sgvf_pkg::sgvf_cfg_t                 cfg,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sgvf_pkg::DirW-1:0]    dir_x,
	output logic signed [sgvf_pkg::DirW-1:0]    dir_y,
	output logic signed [sgvf_pkg::ErrW-1:0]    path_error
);
	import sgvf_pkg::*;

	localparam int KW     = ErrW + GainW + 1;   // gain * e
	localparam int VW     = KW + 1;             // vector component
	localparam int AW     = VW - 1;             // its magnitude
	localparam int MW     = 30;                 // magnitude after scaling
	localparam int ShW    = 4;
	localparam int SqW    = 2 * MW + 1;
	localparam int RootW  = MW + 1;
	localparam int SqSt   = RootW;
	localparam int QW     = 15;
	localparam int NumW   = MW + 15;
	localparam int DivSt  = QW;
	localparam int NStage = 6 + SqSt + 1 + DivSt;
	localparam logic [QW-1:0] UnitQ14 = 15'd16384;
	localparam logic signed [VW-1:0] OneQ16 = 42'sd65536;

	typedef struct packed {
		logic signed [ErrW-1:0] e;
		logic                   negx;
		logic                   negy;
	} side_t;

	logic adv;
	logic [NStage-1:0] vld_q;
	logic out_valid_q;
	logic signed [DirW-1:0] dir_x_q, dir_y_q;
	logic signed [ErrW-1:0] err_q;

	logic signed [KW-1:0] k_s1;
	logic signed [1:0] nx_s1, ny_s1;
	logic signed [ErrW-1:0] e_s1, e_s2;
	logic signed [VW-1:0] vx_s2, vy_s2;
	logic [AW-1:0] ax_s3, ay_s3;
	side_t side_s3, side_s4, side_s5;
	logic [MW-1:0] ax_s4, ay_s4, ax_s5, ay_s5;
	logic [2*MW-1:0] sqx_s5, sqy_s5;

	logic [SqW-1:0]  sq_rem_s  [SqSt+1];
	logic [RootW-1:0] sq_root_s [SqSt+1];
	logic [MW-1:0]   sq_ax_s   [SqSt+1];
	logic [MW-1:0]   sq_ay_s   [SqSt+1];
	side_t           sq_side_s [SqSt+1];

	logic [NumW-1:0]  dv_remx_s [DivSt+1];
	logic [NumW-1:0]  dv_remy_s [DivSt+1];
	logic [QW-1:0]    dv_qx_s   [DivSt+1];
	logic [QW-1:0]    dv_qy_s   [DivSt+1];
	logic [RootW-1:0] dv_n_s    [DivSt+1];
	side_t            dv_side_s [DivSt+1];

	logic signed [1:0] tx, ty;
	logic signed [VW-1:0] vx_d, vy_d;
	logic [AW-1:0] mag_or, ax_sh, ay_sh;
	logic [ShW-1:0] sh;
	logic [QW-1:0] qx_c, qy_c;

	assign adv        = !out_valid_q || out_ready;
	assign item_pop   = adv && item_valid;
	assign out_valid  = out_valid_q;
	assign dir_x      = dir_x_q;
	assign dir_y      = dir_y_q;
	assign path_error = err_q;

	function automatic logic signed [1:0] sign_mul(logic signed [1:0] a, logic signed [1:0] b);
		logic signed [3:0] p;
		p = 4'(a * b);
		return p[1:0];
	endfunction

	function automatic logic signed [VW-1:0] sign_term(logic signed [1:0] s,
		logic signed [VW-1:0] v);
		logic signed [VW-1:0] r;
		case (s)
			SignPos: r = v;
			SignNeg: r = -v;
			default: r = '0;
		endcase
		return r;
	endfunction

	// The tangent and the normal term of each component.
	always_comb begin
		tx   = sign_mul(cfg.direction, ny_s1);
		ty   = -sign_mul(cfg.direction, nx_s1);
		vx_d = sign_term(tx, OneQ16) - sign_term(nx_s1, VW'(k_s1));
		vy_d = sign_term(ty, OneQ16) - sign_term(ny_s1, VW'(k_s1));
	end

	// Both magnitudes are shifted by one count until each fits in 30 bits.
	always_comb begin
		mag_or = ax_s3 | ay_s3;
		sh     = '0;
		for (int i = 0; i < AW - MW; i++) begin
			if (mag_or[MW + i])
				sh = ShW'(i + 1);
		end
		ax_sh = ax_s3 >> sh;
		ay_sh = ay_s3 >> sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[NStage-2:0], item_valid};
			out_valid_q <= vld_q[NStage-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1  <= $signed({1'b0, cfg.gain}) * item.e;
			nx_s1 <= item.nx;
			ny_s1 <= item.ny;
			e_s1  <= item.e;

			vx_s2 <= vx_d;
			vy_s2 <= vy_d;
			e_s2  <= e_s1;

			ax_s3        <= vx_s2[VW-1] ? AW'(-vx_s2) : AW'(vx_s2);
			ay_s3        <= vy_s2[VW-1] ? AW'(-vy_s2) : AW'(vy_s2);
			side_s3.e    <= e_s2;
			side_s3.negx <= vx_s2[VW-1];
			side_s3.negy <= vy_s2[VW-1];

			ax_s4   <= ax_sh[MW-1:0];
			ay_s4   <= ay_sh[MW-1:0];
			side_s4 <= side_s3;

			sqx_s5  <= ax_s4 * ax_s4;
			sqy_s5  <= ay_s4 * ay_s4;
			ax_s5   <= ax_s4;
			ay_s5   <= ay_s4;
			side_s5 <= side_s4;

			sq_rem_s[0]  <= {1'b0, sqx_s5} + {1'b0, sqy_s5};
			sq_root_s[0] <= '0;
			sq_ax_s[0]   <= ax_s5;
			sq_ay_s[0]   <= ay_s5;
			sq_side_s[0] <= side_s5;
		end
	end

	// Square root, one result bit per stage from the top.
	for (genvar j = 0; j < SqSt; j++) begin : g_sqrt
		localparam int B = SqSt - 1 - j;
		logic [SqW:0] trial;
		assign trial = ({{(SqW+1-RootW){1'b0}}, sq_root_s[j]} << (B + 1))
			+ ((SqW+1)'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (adv) begin
				if ({1'b0, sq_rem_s[j]} >= trial) begin
					sq_rem_s[j+1]  <= sq_rem_s[j] - trial[SqW-1:0];
					sq_root_s[j+1] <= sq_root_s[j] | (RootW'(1) << B);
				end else begin
					sq_rem_s[j+1]  <= sq_rem_s[j];
					sq_root_s[j+1] <= sq_root_s[j];
				end
				sq_ax_s[j+1]   <= sq_ax_s[j];
				sq_ay_s[j+1]   <= sq_ay_s[j];
				sq_side_s[j+1] <= sq_side_s[j];
			end
		end
	end

	// Rounded dividend a * 2^14 + floor(N / 2).
	always_ff @(posedge clk) begin
		if (adv) begin
			dv_remx_s[0] <= {1'b0, sq_ax_s[SqSt], 14'b0}
				+ {{(NumW-RootW+1){1'b0}}, sq_root_s[SqSt][RootW-1:1]};
			dv_remy_s[0] <= {1'b0, sq_ay_s[SqSt], 14'b0}
				+ {{(NumW-RootW+1){1'b0}}, sq_root_s[SqSt][RootW-1:1]};
			dv_qx_s[0]   <= '0;
			dv_qy_s[0]   <= '0;
			dv_n_s[0]    <= sq_root_s[SqSt];
			dv_side_s[0] <= sq_side_s[SqSt];
		end
	end

	// Restoring division, one quotient bit per stage for each component.
	for (genvar j = 0; j < DivSt; j++) begin : g_div
		localparam int B = DivSt - 1 - j;
		logic [NumW-1:0] dsh;
		assign dsh = {{(NumW-RootW){1'b0}}, dv_n_s[j]} << B;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (dv_remx_s[j] >= dsh) begin
					dv_remx_s[j+1] <= dv_remx_s[j] - dsh;
					dv_qx_s[j+1]   <= dv_qx_s[j] | (QW'(1) << B);
				end else begin
					dv_remx_s[j+1] <= dv_remx_s[j];
					dv_qx_s[j+1]   <= dv_qx_s[j];
				end
				if (dv_remy_s[j] >= dsh) begin
					dv_remy_s[j+1] <= dv_remy_s[j] - dsh;
					dv_qy_s[j+1]   <= dv_qy_s[j] | (QW'(1) << B);
				end else begin
					dv_remy_s[j+1] <= dv_remy_s[j];
					dv_qy_s[j+1]   <= dv_qy_s[j];
				end
				dv_n_s[j+1]    <= dv_n_s[j];
				dv_side_s[j+1] <= dv_side_s[j];
			end
		end
	end

	always_comb begin
		qx_c = (dv_qx_s[DivSt] > UnitQ14) ? UnitQ14 : dv_qx_s[DivSt];
		qy_c = (dv_qy_s[DivSt] > UnitQ14) ? UnitQ14 : dv_qy_s[DivSt];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dv_n_s[DivSt] == '0) begin
				dir_x_q <= '0;
				dir_y_q <= '0;
			end else begin
				dir_x_q <= dv_side_s[DivSt].negx ? -$signed({1'b0, qx_c})
					: $signed({1'b0, qx_c});
				dir_y_q <= dv_side_s[DivSt].negy ? -$signed({1'b0, qy_c})
					: $signed({1'b0, qy_c});
			end
			err_q <= dv_side_s[DivSt].e;
		end
	end

endmodule

// ===== hdl/square_guidance_vector_field.sv =====
// Square-path guidance vector field.
// Input stream (s_*): one query point per item, signed Q16.8 coordinates.
// Output stream (m_*): one item per point with the unit guidance vector in
// Q1.14 and the path error in Q16.8, in the order the points arrived.
// The APB port holds the centre, half side, circulation sign and gain; write
// it only while no item is in flight.
// A three-stage front end forms the offset, picks the normal and saturates
// the error, then places the item in a short queue. The back end pipeline
// forms the vector, scales it, takes the square root one bit per stage and
// divides one quotient bit per stage.
// Throughput is one item per cycle while m_tready stays high.
// Reset clears all valid flags and loads the register reset values.
// When the receiver holds m_tready low the result stays on m_tdata and the
// back end freezes; the front end keeps taking items until the queue fills,
// then s_tready falls.
module square_guidance_vector_field #(
	parameter int QUEUE_DEPTH = sgvf_pkg::QueueDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // point_x [23:0], point_y [47:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // dir_x [15:0], dir_y [31:16], path_error [55:32]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sgvf_pkg::*;

	sgvf_cfg_t cfg_q;
	sgvf_item_t f_item, q_item;
	logic f_valid, q_full, q_empty, q_pop;
	logic wr_en;
	sgvf_reg_t reg_idx;
	logic signed [DirW-1:0] dir_x, dir_y;
	logic signed [ErrW-1:0] path_error;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = sgvf_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_x  <= '0;
			cfg_q.centre_y  <= '0;
			cfg_q.half_side <= HalfSideRst;
			cfg_q.direction <= SignPos;
			cfg_q.gain      <= GainRst;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CENTRE_X:  cfg_q.centre_x  <= pwdata[CoordW-1:0];
				REG_CENTRE_Y:  cfg_q.centre_y  <= pwdata[CoordW-1:0];
				REG_HALF_SIDE: cfg_q.half_side <= pwdata[HalfW-1:0];
				// The unused code behaves as the negative sign.
				REG_DIRECTION: cfg_q.direction <= ($signed(pwdata[1:0]) == SignUnused)
					? SignNeg : $signed(pwdata[1:0]);
				REG_GAIN:      cfg_q.gain      <= pwdata[GainW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CENTRE_X:  prdata = 32'($signed(cfg_q.centre_x));
			REG_CENTRE_Y:  prdata = 32'($signed(cfg_q.centre_y));
			REG_HALF_SIDE: prdata = {9'b0, cfg_q.half_side};
			REG_DIRECTION: prdata = 32'($signed(cfg_q.direction));
			REG_GAIN:      prdata = {16'b0, cfg_q.gain};
			default:       prdata = '0;
		endcase
	end

	sgvf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.point_x    (s_tdata[23:0]),
		.point_y    (s_tdata[47:24]),
		.cfg        (cfg_q),
		.item_valid (f_valid),
		.item_ready (!q_full),
		.item       (f_item)
	);

	sgvf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.wdata  (f_item),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_item),
		.empty  (q_empty)
	);

	sgvf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!q_empty),
		.item_pop   (q_pop),
		.item       (q_item),
		.cfg        (cfg_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.dir_x      (dir_x),
		.dir_y      (dir_y),
		.path_error (path_error)
	);

	assign m_tdata = {path_error, dir_y, dir_x};

endmodule

// ===== hdl/sgvf_checker.sv =====
module sgvf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_dir_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) >= -16'sd16384
			&& $signed(m_tdata[15:0]) <= 16'sd16384))
		else $error("dir_x beyond unit range");

	a_dir_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:16]) >= -16'sd16384
			&& $signed(m_tdata[31:16]) <= 16'sd16384))
		else $error("dir_y beyond unit range");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind square_guidance_vector_field sgvf_checker u_sgvf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
